// ----- sv/ggrs_pkg.sv -----
// Shared types and constants for the geometric growth rate solver.
package ggrs_pkg;

	localparam int FRAC = 40;
	localparam int WW = 64;
	localparam logic [63:0] WORK_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE = 64'd1 << FRAC;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_LIMIT = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;

	localparam logic [1:0] CFG_INIT = 2'd0;
	localparam logic [1:0] CFG_LIMIT = 2'd1;
	localparam logic [1:0] CFG_TOL = 2'd2;

	// OP_MULF gives the plain floor of |x|*|y|/2^F, unsigned, with no range check
	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_MULF
	} op_t;

	// request to the shared multiply/divide unit
	typedef struct packed {
		logic start;
		op_t op;
		logic signed [63:0] x;
		logic signed [63:0] y;
	} req_t;

	// response from the shared unit
	typedef struct packed {
		logic done;
		logic ok;
		logic signed [63:0] res;
	} rsp_t;

endpackage

// ----- sv/ggrs_muldiv.sv -----
// Shared fixed-point multiply and divide unit, one partial product or quotient bit per cycle.
module ggrs_muldiv (
	input logic clk,
	input logic arst_n,
	input ggrs_pkg::req_t req,
	output ggrs_pkg::rsp_t rsp
);
	import ggrs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_MFIN,
		S_DIV,
		S_DFIN
	} st_t;

	st_t st_q;
	op_t op_q;
	logic neg_q;
	logic [63:0] mx_q;
	logic [63:0] my_q;
	logic [127:0] acc_q;
	logic [127:0] num_q;
	logic [64:0] rem_q;
	logic [6:0] cnt_q;
	logic [1:0] part_q;

	logic [63:0] mxa;
	logic [63:0] mya;
	logic [31:0] xl;
	logic [31:0] yl;
	logic [63:0] pp;
	logic [127:0] pps;
	logic [127:0] rnd;
	logic [64:0] remsh;
	logic [63:0] m;
	logic [127:0] qext;

	assign mxa = req.x[63] ? 64'(-req.x) : 64'(req.x);
	assign mya = req.y[63] ? 64'(-req.y) : 64'(req.y);

	// pick the 32-bit halves for this partial product
	always_comb begin
		xl = part_q[0] ? mx_q[63:32] : mx_q[31:0];
		yl = part_q[1] ? my_q[63:32] : my_q[31:0];
		pp = 64'(xl) * 64'(yl);
		pps = 128'(pp) << (7'(part_q[0]) * 7'd32 + 7'(part_q[1]) * 7'd32);
		rnd = acc_q + (128'd1 << (FRAC - 1));
		remsh = {rem_q[63:0], num_q[127]};
		m = rnd[FRAC +: 64];
		qext = acc_q;
	end

	// sequence the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			rsp <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					// a zero divisor answers at once
					rsp.done <= req.start && (req.op == OP_DIV) && (mya == 64'd0);
					if (req.start) begin
						op_q <= req.op;
						neg_q <= req.x[63] ^ req.y[63];
						mx_q <= mxa;
						my_q <= mya;
						acc_q <= '0;
						part_q <= '0;
						rem_q <= '0;
						cnt_q <= '0;
						num_q <= {24'd0, mxa, 40'd0};
						if (req.op != OP_DIV) begin
							st_q <= S_MUL;
						end else if (mya == 64'd0) begin
							rsp.ok <= 1'b0;
						end else begin
							st_q <= S_DIV;
						end
					end
				end
				S_MUL: begin
					rsp.done <= 1'b0;
					acc_q <= acc_q + pps;
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) begin
						st_q <= S_MFIN;
					end
				end
				S_MFIN: begin
					rsp.done <= 1'b1;
					if (op_q == OP_MULF) begin
						rsp.ok <= 1'b1;
						rsp.res <= $signed(acc_q[FRAC +: 64]);
					end else begin
						rsp.ok <= (rnd[127:FRAC + 64] == '0) && (m <= WORK_LIMIT);
						rsp.res <= neg_q ? -$signed(m) : $signed(m);
					end
					st_q <= S_IDLE;
				end
				S_DIV: begin
					rsp.done <= 1'b0;
					// restoring step, one quotient bit
					num_q <= num_q << 1;
					if (remsh >= {1'b0, my_q}) begin
						rem_q <= remsh - {1'b0, my_q};
						acc_q <= {acc_q[126:0], 1'b1};
					end else begin
						rem_q <= remsh;
						acc_q <= {acc_q[126:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) begin
						st_q <= S_DFIN;
					end
				end
				S_DFIN: begin
					rsp.done <= 1'b1;
					if (qext[127:64] != '0 || qext[63:0] > WORK_LIMIT) begin
						rsp.ok <= 1'b0;
					end else begin
						logic [63:0] qr;
						qr = qext[63:0] + 64'({rem_q[63:0], 1'b0} >= {1'b0, my_q});
						rsp.ok <= qr <= WORK_LIMIT;
						rsp.res <= neg_q ? -$signed(qr) : $signed(qr);
					end
					st_q <= S_IDLE;
				end
				default: begin
					rsp.done <= 1'b0;
					st_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ----- sv/geometric_growth_rate_solver.sv -----
// Top level: Newton solver for the ratio of a geometric layer stack.
// A pass runs n+4 multiplies and four divides, for up to iteration_limit passes;
// a bad layer count answers at once.
// Throughput: one item at a time; in_ready is low from acceptance until the result leaves.
// Every fixed-point multiply and divide but n*q runs on one shared multiply/divide unit; the sequencer here steps it.
// Reset: arst_n clears control state and sets the registers to 1.1, 100 and 2^-40 (raw 1).
module geometric_growth_rate_solver #(
	parameter int MAX_LAYERS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [41:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [6:0] layer_count,
	input logic [47:0] base_layer,
	input logic [47:0] stack_total,
	output logic out_valid,
	input logic out_ready,
	output logic [43:0] ratio,
	output logic [1:0] status,
	output logic [7:0] iterations_used
);
	import ggrs_pkg::*;

	typedef enum logic [4:0] {
		P_IDLE,
		P_CHK,
		P_POW,
		P_POWW,
		P_T1,
		P_T1W,
		P_H,
		P_HW,
		P_NQ,
		P_NQW,
		P_T2,
		P_T2W,
		P_D1,
		P_D1W,
		P_D2,
		P_D2W,
		P_ST,
		P_STW,
		P_UPD,
		P_TOLW,
		P_OUT
	} ph_t;

	ph_t ph_q;
	logic [41:0] init_q;
	logic [7:0] lim_q;
	logic [39:0] tol_q;
	logic [6:0] n_q;
	logic signed [63:0] a_q;
	logic signed [63:0] tot_q;
	logic signed [63:0] r_q;
	logic signed [63:0] d_q;
	logic signed [63:0] p_q;
	logic signed [63:0] q_q;
	logic signed [63:0] pm1_q;
	logic signed [63:0] err_q;
	logic signed [63:0] t_q;
	logic [6:0] k_q;
	logic [7:0] used_q;
	req_t req;
	rsp_t rsp;

	logic signed [64:0] sum;
	logic signed [63:0] sa;
	logic signed [63:0] sb;
	logic [63:0] sm;
	logic [63:0] qm;
	logic [70:0] nqw;
	logic [63:0] em;

	ggrs_muldiv u_md (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// a register write takes the idle slot when both arrive together
	assign cfg_ready = (ph_q == P_IDLE);
	assign in_ready = (ph_q == P_IDLE) && !cfg_valid;
	assign out_valid = (ph_q == P_OUT);

	// shared adder for the differences in a pass
	always_comb begin
		sa = r_q;
		sb = ONE;
		case (ph_q)
			P_CHK: begin sa = r_q; sb = ONE; end
			P_T1: begin sa = p_q; sb = ONE; end
			P_NQ: begin sa = rsp.res; sb = tot_q; end
			P_D1: begin sa = rsp.res; sb = pm1_q; end
			P_UPD: begin sa = r_q; sb = rsp.res; end
			default: begin sa = r_q; sb = ONE; end
		endcase
		sum = 65'(sa) - 65'(sb);
		sm = sum[64] ? 64'(-sum) : 64'(sum);
		qm = q_q[63] ? 64'(-q_q) : q_q;
		nqw = 71'(qm) * 71'(n_q);
		em = err_q[63] ? 64'(-err_q) : err_q;
	end

	// sequence the Newton passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= P_IDLE;
			init_q <= 42'd1209462790554;
			lim_q <= 8'd100;
			tol_q <= 40'd1;
			status <= ST_OK;
			req <= '0;
		end else begin
			case (ph_q)
				P_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							CFG_INIT: init_q <= cfg_data;
							CFG_LIMIT: lim_q <= cfg_data[7:0];
							CFG_TOL: tol_q <= cfg_data[39:0];
							default: ;
						endcase
					end else if (in_valid) begin
						n_q <= layer_count;
						a_q <= 64'(base_layer);
						tot_q <= 64'(stack_total);
						r_q <= 64'(init_q);
						used_q <= '0;
						if (layer_count == 7'd0 || 32'(layer_count) > MAX_LAYERS) begin
							status <= ST_FAIL;
							ph_q <= P_OUT;
						end else begin
							ph_q <= P_CHK;
						end
					end
				end
				P_CHK: begin
					p_q <= ONE;
					q_q <= ONE;
					k_q <= '0;
					d_q <= sum[63:0];
					if (used_q >= lim_q) begin
						status <= ST_LIMIT;
						ph_q <= P_OUT;
					end else if (sm > WORK_LIMIT || sum == '0) begin
						status <= ST_FAIL;
						ph_q <= P_OUT;
					end else begin
						ph_q <= P_POW;
					end
				end
				P_POW: begin
					if (k_q == n_q) begin
						ph_q <= P_T1;
					end else begin
						q_q <= p_q;
						req <= '{start: 1'b1, op: OP_MUL, x: p_q, y: r_q};
						ph_q <= P_POWW;
					end
				end
				P_POWW: begin
					req.start <= 1'b0;
					if (rsp.done) begin
						p_q <= rsp.res;
						k_q <= k_q + 7'd1;
						ph_q <= rsp.ok ? P_POW : P_OUT;
						status <= ST_FAIL;
					end
				end
				P_T1: begin
					pm1_q <= sum[63:0];
					status <= ST_FAIL;
					if (sm > WORK_LIMIT) begin
						ph_q <= P_OUT;
					end else begin
						req <= '{start: 1'b1, op: OP_MUL, x: a_q, y: sum[63:0]};
						ph_q <= P_T1W;
					end
				end
				P_T1W: begin
					if (rsp.done) begin
						req <= '{start: rsp.ok, op: OP_DIV, x: rsp.res, y: d_q};
						ph_q <= rsp.ok ? P_HW : P_OUT;
					end else begin
						req.start <= 1'b0;
					end
				end
				P_HW: begin
					req.start <= 1'b0;
					if (rsp.done) begin
						ph_q <= rsp.ok ? P_NQ : P_OUT;
					end
				end
				P_NQ: begin
					err_q <= sum[63:0];
					if (sm > WORK_LIMIT || nqw > 71'(WORK_LIMIT)) begin
						ph_q <= P_OUT;
					end else begin
						req <= '{start: 1'b1, op: OP_MUL,
							x: q_q[63] ? -$signed(nqw[63:0]) : $signed(nqw[63:0]),
							y: d_q};
						ph_q <= P_NQW;
					end
				end
				P_NQW: begin
					req.start <= 1'b0;
					if (rsp.done) begin
						ph_q <= rsp.ok ? P_D1 : P_OUT;
					end
				end
				P_D1: begin
					if (sm > WORK_LIMIT) begin
						ph_q <= P_OUT;
					end else begin
						req <= '{start: 1'b1, op: OP_MUL, x: a_q, y: sum[63:0]};
						ph_q <= P_D1W;
					end
				end
				P_D1W: begin
					if (rsp.done) begin
						req <= '{start: rsp.ok, op: OP_DIV, x: rsp.res, y: d_q};
						ph_q <= rsp.ok ? P_D2W : P_OUT;
					end else begin
						req.start <= 1'b0;
					end
				end
				P_D2W: begin
					if (rsp.done) begin
						req <= '{start: rsp.ok, op: OP_DIV, x: rsp.res, y: d_q};
						ph_q <= rsp.ok ? P_T2W : P_OUT;
					end else begin
						req.start <= 1'b0;
					end
				end
				P_T2W: begin
					if (rsp.done) begin
						req <= '{start: rsp.ok, op: OP_DIV, x: err_q, y: rsp.res};
						ph_q <= rsp.ok ? P_STW : P_OUT;
					end else begin
						req.start <= 1'b0;
					end
				end
				P_STW: begin
					req.start <= 1'b0;
					if (rsp.done) begin
						ph_q <= rsp.ok ? P_UPD : P_OUT;
					end
				end
				P_UPD: begin
					// accept the update only if it stays in the ratio range
					if (sm > WORK_LIMIT || sum[64] || sum[63:0] > 64'hFFF_FFFF_FFFF) begin
						ph_q <= P_OUT;
					end else begin
						r_q <= sum[63:0];
						used_q <= used_q + 8'd1;
						// floor of tolerance times total bounds the error magnitude
						req <= '{start: 1'b1, op: OP_MULF, x: 64'(tol_q), y: tot_q};
						ph_q <= P_TOLW;
					end
				end
				P_TOLW: begin
					req.start <= 1'b0;
					if (rsp.done) begin
						if (em <= $unsigned(rsp.res)) begin
							status <= ST_OK;
							ph_q <= P_OUT;
						end else begin
							ph_q <= P_CHK;
						end
					end
				end
				P_OUT: begin
					if (out_ready) begin
						ph_q <= P_IDLE;
					end
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	assign ratio = r_q[43:0];
	assign iterations_used = used_q;

`ifndef NO_ASSERTIONS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != P_IDLE) |-> !in_ready) else $error("ready while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(ratio) && $stable(status))
		else $error("result moved while stalled");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != P_IDLE && ph_q != P_OUT) |-> used_q <= lim_q)
		else $error("update count beyond limit");
`endif
endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the geometric growth rate solver.
module tb;
	import ggrs_pkg::*;

	// Holds the register copies, predicts each solve and checks result beats in order
	class solve_scoreboard;
		typedef struct {
			bit [43:0] ratio;
			bit [1:0] status;
			bit [7:0] used;
		} solve_t;

		solve_t pending[$];
		bit [41:0] init_ratio;
		bit [7:0] iter_limit;
		bit [39:0] tolerance;
		int faults;

		function new();
			init_ratio = 42'd1209462790554;
			iter_limit = 8'd100;
			tolerance = 40'd1;
			faults = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [41:0] data);
			case (idx)
				CFG_INIT: init_ratio = data;
				CFG_LIMIT: iter_limit = data[7:0];
				CFG_TOL: tolerance = data[39:0];
				default: ;
			endcase
		endfunction

		function bit [63:0] mag(longint v);
			return v < 0 ? 64'(-v) : 64'(v);
		endfunction

		function bit add_ok(longint x, longint y, output longint s);
			s = x + y;
			return mag(s) <= WORK_LIMIT;
		endfunction

		// rounded product, ties away from zero on the magnitude
		function bit mul_ok(longint x, longint y, output longint res);
			bit [127:0] p;
			bit [127:0] m;
			p = 128'(mag(x)) * 128'(mag(y)) + (128'd1 << (FRAC - 1));
			m = p >> FRAC;
			res = 0;
			if (m > 128'(WORK_LIMIT))
				return 0;
			res = ((x < 0) != (y < 0)) ? -longint'(m[63:0]) : longint'(m[63:0]);
			return 1;
		endfunction

		// rounded quotient x*2^F/y
		function bit div_ok(longint x, longint y, output longint res);
			bit [127:0] num;
			bit [127:0] q;
			bit [127:0] rem;
			bit [127:0] my;
			res = 0;
			my = 128'(mag(y));
			if (my == 0)
				return 0;
			num = 128'(mag(x)) << FRAC;
			q = num / my;
			rem = num % my;
			if (q > 128'(WORK_LIMIT))
				return 0;
			if (rem * 2 >= my)
				q = q + 1;
			if (q > 128'(WORK_LIMIT))
				return 0;
			res = ((x < 0) != (y < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
			return 1;
		endfunction

		// one Newton update; returns ST_OK or ST_FAIL, r advances only on success
		function bit [1:0] newton_update(int n, longint a, longint total, inout longint r,
				output bit conv);
			longint one, d, p, q, pm1, t, h, err, nq, num, dh, step, rn;
			bit [127:0] wide;
			conv = 0;
			one = longint'(ONE);
			p = one;
			q = one;
			if (!add_ok(r, -one, d) || d == 0)
				return ST_FAIL;
			for (int k = 0; k < n; k++) begin
				q = p;
				if (!mul_ok(p, r, p))
					return ST_FAIL;
			end
			if (!add_ok(p, -one, pm1))
				return ST_FAIL;
			if (!mul_ok(a, pm1, t) || !div_ok(t, d, h))
				return ST_FAIL;
			if (!add_ok(h, -total, err))
				return ST_FAIL;
			wide = 128'(n) * 128'(mag(q));
			if (wide > 128'(WORK_LIMIT))
				return ST_FAIL;
			nq = q < 0 ? -longint'(wide[63:0]) : longint'(wide[63:0]);
			if (!mul_ok(nq, d, t) || !add_ok(t, -pm1, num))
				return ST_FAIL;
			if (!mul_ok(a, num, t) || !div_ok(t, d, t) || !div_ok(t, d, dh))
				return ST_FAIL;
			if (!div_ok(err, dh, step))
				return ST_FAIL;
			if (!add_ok(r, -step, rn))
				return ST_FAIL;
			if (rn < 0 || rn > longint'(64'hFFF_FFFF_FFFF))
				return ST_FAIL;
			r = rn;
			conv = ((128'(mag(err)) << FRAC) <= 128'(tolerance) * 128'(total));
			return ST_OK;
		endfunction

		// note an accepted input beat and queue its solve
		function void note_input(logic [6:0] n, logic [47:0] a, logic [47:0] total);
			solve_t s;
			longint r;
			bit conv;
			r = longint'(init_ratio);
			s.used = 0;
			s.status = ST_FAIL;
			if (n >= 1 && n <= 64) begin
				forever begin
					if (s.used >= iter_limit) begin
						s.status = ST_LIMIT;
						break;
					end
					s.status = newton_update(int'(n), longint'(a), longint'(total), r, conv);
					if (s.status != ST_OK)
						break;
					s.used++;
					if (conv)
						break;
				end
			end
			s.ratio = r[43:0];
			pending.push_back(s);
		endfunction

		// check a result beat against the oldest expectation
		function void check_result(logic [43:0] ratio, logic [1:0] status, logic [7:0] used);
			solve_t s;
			if (pending.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: ratio %h status %0d iterations %0d",
						ratio, status, used);
				return;
			end
			s = pending.pop_front();
			if (ratio !== s.ratio || status !== s.status || used !== s.used) begin
				faults++;
				if (faults <= 10)
					$display("mismatch: exp ratio %h status %0d iter %0d, got %h %0d %0d",
						s.ratio, s.status, s.used, ratio, status, used);
			end
		endfunction
	endclass

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam longint CYCLE_LIMIT = 40_000_000;
	localparam logic [41:0] RATIO_ONE = 42'd1 << 40;
	localparam logic [41:0] RATIO_MAX = 42'h3FF_FFFF_FFFF;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [41:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [6:0] layer_count;
	logic [47:0] base_layer;
	logic [47:0] stack_total;
	logic out_valid;
	logic out_ready;
	logic [43:0] ratio;
	logic [1:0] status;
	logic [7:0] iterations_used;

	solve_scoreboard sb;
	bit idle_on;
	longint cycles;

	geometric_growth_rate_solver u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.layer_count(layer_count),
		.base_layer(base_layer),
		.stack_total(stack_total),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ratio(ratio),
		.status(status),
		.iterations_used(iterations_used)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// drain results with a random stall before each beat while idling is on
	initial begin
		int stall;
		out_ready <= 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 12) : 0;
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(ratio, status, iterations_used);
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [41:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	// hold input until every result is back and the block has settled
	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic configure(logic [41:0] init, logic [7:0] lim, logic [39:0] tol);
		drain();
		write_reg(CFG_INIT, init);
		write_reg(CFG_LIMIT, {34'd0, lim});
		write_reg(CFG_TOL, {2'd0, tol});
		cfg_valid <= 0;
	endtask

	task automatic send_item(logic [6:0] n, logic [47:0] a, logic [47:0] total);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		layer_count <= n;
		base_layer <= a;
		stack_total <= total;
		do @(posedge clk); while (!in_ready);
		sb.note_input(n, a, total);
	endtask

	// build a solvable stack from a chosen ratio, or plain noise
	task automatic random_item();
		real r, a, s, pw;
		int n;
		longint a_fx, t_fx;
		if ($urandom_range(0, 4) == 0) begin
			send_item(7'($urandom_range(0, 127)), 48'({$urandom, $urandom}),
				48'({$urandom, $urandom}));
			return;
		end
		r = 1.0 + $urandom_range(1, 600) / 1000.0;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64) : $urandom_range(2, 16);
		a = $urandom_range(1, 4000) / 1000.0;
		pw = 1.0;
		for (int k = 0; k < n; k++)
			pw = pw * r;
		s = (pw - 1.0) / (r - 1.0);
		if (a * s > 250.0)
			a = 250.0 / s;
		a_fx = longint'(a * 1099511627776.0);
		t_fx = longint'(a * s * 1099511627776.0) + longint'($urandom_range(0, 1000));
		if (a_fx == 0)
			a_fx = 1;
		send_item(7'(n), a_fx[47:0], t_fx[47:0]);
	endtask

	initial begin
		logic [41:0] init;
		logic [63:0] wide;
		sb = new();
		cycles = 0;
		idle_on = 1;
		arst_n = 0;
		cfg_valid <= 0;
		cfg_index <= CFG_INIT;
		cfg_data <= 0;
		in_valid <= 0;
		layer_count <= 0;
		base_layer <= 0;
		stack_total <= 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings: layer count bounds, zero thickness, single layer, tiny and extreme totals
		send_item(7'd0, 48'd1 << 40, 48'd3 << 40);
		send_item(7'd65, 48'd1 << 40, 48'd3 << 40);
		send_item(7'd127, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_item(7'd1, 48'd1 << 40, 48'd1 << 40);
		send_item(7'd3, 48'd0, 48'd1 << 40);
		send_item(7'd3, 48'd1 << 40, 48'd3466411212390);
		send_item(7'd5, 48'd1 << 40, 48'd1);
		send_item(7'd64, 48'd1, 48'hFFFF_FFFF_FFFF);
		send_item(7'd64, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);

		// ratio of exactly one and the largest start, tight limit, zero tolerance
		configure(RATIO_ONE, 8'd1, 40'd0);
		send_item(7'd4, 48'd1 << 40, 48'd5 << 40);
		configure(RATIO_MAX, 8'd1, 40'd0);
		send_item(7'd4, 48'd1 << 40, 48'd5 << 40);
		send_item(7'd2, 48'd1 << 38, 48'd1 << 40);

		// no updates allowed; spare index must be ignored
		configure(42'd1209462790554, 8'd0, 40'd0);
		write_reg(CFG_SPARE, RATIO_MAX);
		cfg_valid <= 0;
		send_item(7'd8, 48'd1 << 40, 48'd20 << 40);

		// widest limit and tolerance
		configure(42'd1209462790554, 8'd255, 40'hFF_FFFF_FFFF);
		send_item(7'd8, 48'd1 << 40, 48'd20 << 40);
		send_item(7'd64, 48'd1 << 30, 48'd1 << 44);

		// random phases with fresh settings, idling on and off
		for (int ph = 0; ph < 6; ph++) begin
			case ($urandom_range(0, 5))
				0: init = RATIO_ONE;
				1: init = RATIO_MAX;
				default: init = RATIO_ONE + 42'($urandom_range(1, 700)) * 42'd1099511628;
			endcase
			wide = {$urandom, $urandom} >> $urandom_range(0, 63);
			configure(init, 8'($urandom_range(1, 16)), wide[39:0]);
			idle_on = (ph % 3) != 2;
			for (int i = 0; i < 50; i++)
				random_item();
		end

		drain();
		repeat (50) @(posedge clk);
		if (sb.faults == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ----- files.f -----
sv/ggrs_pkg.sv
sv/ggrs_muldiv.sv
sv/geometric_growth_rate_solver.sv
sim/tb.sv
